// ===== rtl/msb_first_bit_field_reader_unit_assert.svh =====
// Assertion macros used by the checker module.
`ifndef MSB_FIRST_BIT_FIELD_READER_UNIT_ASSERT_SVH
`define MSB_FIRST_BIT_FIELD_READER_UNIT_ASSERT_SVH

// Clocked check, muted while reset is held
`define MBFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also runs through reset
`define MBFR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/mbfr_pkg.sv =====
package mbfr_pkg;

    // Fixed geometry of the stream
    localparam int WORD_BITS        = 32;
    localparam int BUF_BITS         = 2 * WORD_BITS;
    localparam int CNT_BITS         = 7;
    localparam int POS_BITS         = 16;
    localparam int WIDTH_BITS       = 5;
    localparam int NEED_BITS        = 6;
    localparam int MBFR_PREFIX_BITS = 5;

    // Request kinds
    typedef enum logic [1:0] {
        KIND_PUSH  = 2'd0,
        KIND_FIXED = 2'd1,
        KIND_VAR   = 2'd2
    } kind_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_FULL  = 2'd2,
        ST_PAST  = 2'd3
    } status_t;

    // Past-total check wins over the buffered-bits check
    function automatic status_t check_need(
        input logic [POS_BITS-1:0]  consumed,
        input logic [POS_BITS-1:0]  total,
        input logic [CNT_BITS-1:0]  buffered,
        input logic [NEED_BITS-1:0] need
    );
        logic [POS_BITS:0] reach;
        status_t           st;
        reach = {1'b0, consumed} + (POS_BITS+1)'(need);
        if (reach > {1'b0, total}) begin
            st = ST_PAST;
        end else if (CNT_BITS'(need) > buffered) begin
            st = ST_SHORT;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

    // Field of n bits sitting in the low bits of raw; unsigned or sign-magnitude
    function automatic logic [WORD_BITS-1:0] decode_field(
        input logic [WORD_BITS-1:0]  raw,
        input logic [WIDTH_BITS-1:0] n,
        input logic                  sgn
    );
        logic [WORD_BITS-1:0]  field;
        logic [WORD_BITS-1:0]  mag;
        logic [WIDTH_BITS-1:0] top;
        logic [WORD_BITS-1:0]  res;
        field = raw & ((WORD_BITS'(1) << n) - WORD_BITS'(1));
        top   = n - WIDTH_BITS'(1);
        mag   = field & ((WORD_BITS'(1) << top) - WORD_BITS'(1));
        if (n == '0) begin
            res = '0;
        end else if (!sgn) begin
            res = field;
        end else if (field[top]) begin
            res = WORD_BITS'(0) - mag;
        end else begin
            res = mag;
        end
        return res;
    endfunction

endpackage

// ===== rtl/msb_first_bit_field_reader_unit.sv =====
// MSB-first bit field reader: pushes 32-bit words into a 64-bit bit buffer and
// unpacks fixed or length-prefixed fields from its oldest bits.
// Path: a request lands in the request register, then its result in the result
// register; throughput one request per cycle unless m_ready stalls the result
// stage, set by the single shift-and-mask pass that updates the buffer state.
// Reset (aresetn, synchronous, active low) empties the buffer, zeroes counters.
module msb_first_bit_field_reader_unit
    import mbfr_pkg::*;
#(
    parameter int SIZE_PREFIX_BITS = MBFR_PREFIX_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_we,
    input  logic [POS_BITS-1:0]    cfg_wdata,
    // request channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_kind,
    input  logic [WORD_BITS-1:0]   s_word,
    input  logic [WIDTH_BITS-1:0]  s_width,
    input  logic                   s_is_signed,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [WORD_BITS-1:0] m_value,
    output logic [1:0]             m_status,
    output logic                   m_finished
);

    // request register
    logic                  in_valid_reg;
    logic [1:0]            kind_reg;
    logic [WORD_BITS-1:0]  word_reg;
    logic [WIDTH_BITS-1:0] width_reg;
    logic                  sgn_reg;

    // stream state
    logic [BUF_BITS-1:0]   buf_reg, buf_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [POS_BITS-1:0]   consumed_reg, consumed_next;
    logic [POS_BITS-1:0]   total_reg;

    // result register
    logic                  out_valid_reg;
    logic [WORD_BITS-1:0]  value_reg, value_next;
    status_t               status_reg, status_next;
    logic                  finished_reg;

    logic                  advance;
    logic                  fire;

    // datapath intermediates
    logic [CNT_BITS-1:0]   sh_fix, sh_pre, sh_var;
    logic [BUF_BITS-1:0]   win_fix, win_pre, win_var;
    logic [WIDTH_BITS-1:0] pre_n;
    logic [NEED_BITS-1:0]  need_var;
    status_t               st_fix, st_pre, st_var;

    // result stage frees when empty or drained
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // shifted windows onto the oldest buffered bits
    assign sh_fix   = cnt_reg - CNT_BITS'(width_reg);
    assign win_fix  = buf_reg >> sh_fix[5:0];
    assign sh_pre   = cnt_reg - CNT_BITS'(SIZE_PREFIX_BITS);
    assign win_pre  = buf_reg >> sh_pre[5:0];
    assign pre_n    = WIDTH_BITS'(win_pre[SIZE_PREFIX_BITS-1:0]);
    assign need_var = NEED_BITS'(SIZE_PREFIX_BITS) + NEED_BITS'(pre_n);
    assign sh_var   = cnt_reg - CNT_BITS'(need_var);
    assign win_var  = buf_reg >> sh_var[5:0];

    assign st_fix = check_need(consumed_reg, total_reg, cnt_reg, NEED_BITS'(width_reg));
    assign st_pre = check_need(consumed_reg, total_reg, cnt_reg,
                               NEED_BITS'(SIZE_PREFIX_BITS));
    assign st_var = check_need(consumed_reg, total_reg, cnt_reg, need_var);

    // one pass: decode, status, state update
    always_comb begin
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        consumed_next = consumed_reg;
        value_next    = '0;
        status_next   = ST_OK;
        case (kind_reg)
            KIND_PUSH: begin
                if (cnt_reg > CNT_BITS'(WORD_BITS)) begin
                    status_next = ST_FULL;
                end else begin
                    buf_next = {buf_reg[WORD_BITS-1:0], word_reg};
                    cnt_next = cnt_reg + CNT_BITS'(WORD_BITS);
                end
            end
            KIND_FIXED: begin
                status_next = st_fix;
                if (st_fix == ST_OK) begin
                    value_next    = decode_field(win_fix[WORD_BITS-1:0], width_reg, sgn_reg);
                    cnt_next      = cnt_reg - CNT_BITS'(width_reg);
                    consumed_next = consumed_reg + POS_BITS'(width_reg);
                end
            end
            KIND_VAR: begin
                if (st_pre != ST_OK) begin
                    status_next = st_pre;
                end else begin
                    status_next = st_var;
                    if (st_var == ST_OK) begin
                        value_next    = decode_field(win_var[WORD_BITS-1:0], pre_n,
                                                     sgn_reg);
                        cnt_next      = cnt_reg - CNT_BITS'(need_var);
                        consumed_next = consumed_reg + POS_BITS'(need_var);
                    end
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            kind_reg  <= s_kind;
            word_reg  <= s_word;
            width_reg <= s_width;
            sgn_reg   <= s_is_signed;
        end
    end

    // stream state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg      <= '0;
            cnt_reg      <= '0;
            consumed_reg <= '0;
            total_reg    <= '0;
        end else begin
            if (fire) begin
                buf_reg      <= buf_next;
                cnt_reg      <= cnt_next;
                consumed_reg <= consumed_next;
            end
            if (cfg_we) begin
                total_reg <= cfg_wdata;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (fire) begin
            value_reg    <= value_next;
            status_reg   <= status_next;
            finished_reg <= (consumed_next == total_reg);
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_value    = value_reg;
    assign m_status   = status_reg;
    assign m_finished = finished_reg;

endmodule

// ===== rtl/mbfr_checker.sv =====
`include "msb_first_bit_field_reader_unit_assert.svh"

module mbfr_checker
    import mbfr_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   cfg_we,
    input logic [POS_BITS-1:0]    cfg_wdata,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [1:0]             s_kind,
    input logic [WORD_BITS-1:0]   s_word,
    input logic [WIDTH_BITS-1:0]  s_width,
    input logic                   s_is_signed,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic signed [WORD_BITS-1:0] m_value,
    input logic [1:0]             m_status,
    input logic                   m_finished
);

    // a refused request never carries a value
    `MBFR_ASSERT(a_fail_value_zero, m_valid && m_status != ST_OK |-> m_value == '0, "nonzero value on failed request")

    // a drained result stage always frees the request side
    `MBFR_ASSERT(a_ready_when_drained, m_ready |-> s_ready, "request side stalled while result side drains")

    // reset leaves no result pending
    `MBFR_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "result valid right after reset")

    // stalled result holds
    `MBFR_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status) && $stable(m_finished), "stalled result changed")

endmodule

bind msb_first_bit_field_reader_unit mbfr_checker u_mbfr_checker (.*);

// ===== dv/msb_first_bit_field_reader_unit_test.sv =====
`timescale 1ns / 1ps

module msb_first_bit_field_reader_unit_test;
    import mbfr_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int unsigned WATCHDOG_LIMIT = 400;
    localparam int unsigned DRAIN_CYCLES = 6;

    typedef struct {
        logic [1:0]            kind;
        logic [WORD_BITS-1:0]  word;
        logic [WIDTH_BITS-1:0] width;
        logic                  sgn;
    } field_req_t;

    typedef struct {
        logic [WORD_BITS-1:0] value;
        status_t              status;
        logic                 finished;
    } field_result_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [POS_BITS-1:0]   cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_kind = '0;
    logic [WORD_BITS-1:0]  s_word = '0;
    logic [WIDTH_BITS-1:0] s_width = '0;
    logic                  s_is_signed = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [WORD_BITS-1:0] m_value;
    logic [1:0]            m_status;
    logic                  m_finished;

    msb_first_bit_field_reader_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_word      (s_word),
        .s_width     (s_width),
        .s_is_signed (s_is_signed),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_status    (m_status),
        .m_finished  (m_finished)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Shadow state of the unpacker
    logic [BUF_BITS-1:0] stream_bits = '0;
    logic [CNT_BITS-1:0] bits_held = '0;
    logic [POS_BITS-1:0] bits_taken = '0;
    logic [POS_BITS-1:0] bit_limit = '0;

    field_req_t    request_q[$];
    field_result_t expected_fields[$];
    field_req_t    cur_req;

    int unsigned n_errors = 0;
    int unsigned n_push = 0;
    int unsigned n_fixed = 0;
    int unsigned n_var = 0;
    int unsigned n_spare = 0;
    int unsigned n_results = 0;
    int unsigned n_finished = 0;
    int unsigned n_refused = 0;
    int unsigned n_settings = 0;

    task automatic report_mismatch(string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Past-total check first, then buffered bits
    function automatic status_t need_status(int unsigned need);
        if (32'(bits_taken) + need > 32'(bit_limit))
            return ST_PAST;
        if (need > 32'(bits_held))
            return ST_SHORT;
        return ST_OK;
    endfunction

    // n bits sitting skip bits below the oldest buffered bit
    function automatic logic [WORD_BITS-1:0] field_at(int unsigned skip, int unsigned n,
                                                      logic sgn);
        logic [BUF_BITS-1:0]  raw;
        logic [WORD_BITS-1:0] mag;
        int unsigned          sh;
        if (n == 0)
            return '0;
        sh  = 32'(bits_held) - skip - n;
        raw = (stream_bits >> sh) & ((64'd1 << n) - 64'd1);
        if (!sgn)
            return raw[WORD_BITS-1:0];
        mag = raw[WORD_BITS-1:0] & ((32'd1 << (n - 1)) - 32'd1);
        if (raw[n-1])
            return 32'd0 - mag;
        return mag;
    endfunction

    function automatic void take_bits(int unsigned n);
        bits_held  = bits_held - CNT_BITS'(n);
        bits_taken = bits_taken + POS_BITS'(n);
    endfunction

    // One request in, one expected result out; updates the shadow state
    function automatic field_result_t unpack_predict(field_req_t rq);
        field_result_t res;
        int unsigned   plen;
        res.value  = '0;
        res.status = ST_OK;
        case (rq.kind)
            KIND_PUSH: begin
                if (bits_held > WORD_BITS) begin
                    res.status = ST_FULL;
                end else begin
                    stream_bits = {stream_bits[WORD_BITS-1:0], rq.word};
                    bits_held   = bits_held + CNT_BITS'(WORD_BITS);
                end
            end
            KIND_FIXED: begin
                res.status = need_status(rq.width);
                if (res.status == ST_OK) begin
                    res.value = field_at(0, rq.width, rq.sgn);
                    take_bits(rq.width);
                end
            end
            KIND_VAR: begin
                res.status = need_status(MBFR_PREFIX_BITS);
                if (res.status == ST_OK) begin
                    plen = field_at(0, MBFR_PREFIX_BITS, 1'b0);
                    res.status = need_status(MBFR_PREFIX_BITS + plen);
                    if (res.status == ST_OK) begin
                        res.value = field_at(MBFR_PREFIX_BITS, plen, rq.sgn);
                        take_bits(MBFR_PREFIX_BITS + plen);
                    end
                end
            end
            default: ;
        endcase
        res.finished = (bits_taken == bit_limit);
        return res;
    endfunction

    function automatic field_req_t mk_req(logic [1:0] kind, logic [WORD_BITS-1:0] word,
                                          logic [WIDTH_BITS-1:0] width, logic sgn);
        field_req_t rq;
        rq.kind  = kind;
        rq.word  = word;
        rq.width = width;
        rq.sgn   = sgn;
        return rq;
    endfunction

    // Mostly pushes and reads with small widths so fields line up with the limit
    function automatic field_req_t rand_req();
        field_req_t  rq;
        int unsigned pick;
        pick     = $urandom_range(0, 99);
        rq.word  = $urandom();
        rq.width = ($urandom_range(0, 3) == 0) ? WIDTH_BITS'($urandom_range(0, 31))
                                               : WIDTH_BITS'($urandom_range(0, 8));
        rq.sgn   = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0)
            rq.word = $urandom_range(0, 1) ? '1 : '0;
        if (pick < 35)
            rq.kind = KIND_PUSH;
        else if (pick < 72)
            rq.kind = KIND_FIXED;
        else if (pick < 97)
            rq.kind = KIND_VAR;
        else
            rq.kind = KIND_SPARE;
        return rq;
    endfunction

    function automatic int unsigned draw_wait(bit quiet);
        return quiet ? 0 : $urandom_range(0, 9);
    endfunction

    // Request driver
    int unsigned send_wait = 0;
    bit          send_quiet = 1'b0;

    always @(posedge aclk) begin
        logic fire;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait = 0;
        end else begin
            fire = s_valid && s_ready;
            if (fire) begin
                expected_fields.push_back(unpack_predict(cur_req));
                case (cur_req.kind)
                    KIND_PUSH:  n_push++;
                    KIND_FIXED: n_fixed++;
                    KIND_VAR:   n_var++;
                    default:    n_spare++;
                endcase
                if ($urandom_range(0, 39) == 0)
                    send_quiet = !send_quiet;
                send_wait = draw_wait(send_quiet);
            end
            if (!s_valid || fire) begin
                if (send_wait == 0 && request_q.size() != 0) begin
                    cur_req = request_q.pop_front();
                    s_kind      <= cur_req.kind;
                    s_word      <= cur_req.word;
                    s_width     <= cur_req.width;
                    s_is_signed <= cur_req.sgn;
                    s_valid     <= 1'b1;
                end else begin
                    if (send_wait != 0)
                        send_wait--;
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    int unsigned recv_wait = 0;
    bit          recv_quiet = 1'b0;

    always @(posedge aclk) begin
        field_result_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_fields.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: value %h status %0d",
                                              m_value, m_status));
                end else begin
                    want = expected_fields.pop_front();
                    if (m_value !== want.value)
                        report_mismatch($sformatf("value %h, expected %h",
                                                  m_value, want.value));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_status, want.status));
                    if (m_finished !== want.finished)
                        report_mismatch($sformatf("finished %b, expected %b",
                                                  m_finished, want.finished));
                    if (want.finished)
                        n_finished++;
                    if (want.status != ST_OK)
                        n_refused++;
                end
                if ($urandom_range(0, 39) == 0)
                    recv_quiet = !recv_quiet;
                recv_wait = draw_wait(recv_quiet);
            end else if (recv_wait != 0) begin
                recv_wait--;
            end
            m_ready <= (recv_wait == 0);
        end
    end

    // Watchdog on cycles without any handshake
    int unsigned stuck_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", stuck_cycles);
                $display("[msb_first_bit_field_reader_unit] ERROR");
                $finish;
            end
        end
    end

    // Wait until every request is through and the pipeline has drained
    task automatic wait_idle();
        while (request_q.size() != 0 || s_valid || expected_fields.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_bit_limit(logic [POS_BITS-1:0] v);
        wait_idle();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        bit_limit = v;
        n_settings++;
    endtask

    task automatic queue_random(int unsigned count);
        repeat (count) request_q.push_back(rand_req());
    endtask

    // Stimulus sequence
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero limit: only zero-width reads get through
        set_bit_limit(16'd0);
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd0, 1'b0));
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd0, 1'b1));
        request_q.push_back(mk_req(KIND_FIXED, 32'hFFFFFFFF, 5'd3, 1'b0));
        request_q.push_back(mk_req(KIND_VAR, 32'h0, 5'd31, 1'b1));
        request_q.push_back(mk_req(KIND_SPARE, 32'hFFFFFFFF, 5'd31, 1'b1));

        // full limit: empty reads, buffer full, extreme widths, negative zero
        set_bit_limit(16'hFFFF);
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd1, 1'b0));
        request_q.push_back(mk_req(KIND_VAR, 32'h0, 5'd0, 1'b0));
        request_q.push_back(mk_req(KIND_PUSH, 32'hFFFFFFFF, 5'd0, 1'b0));
        request_q.push_back(mk_req(KIND_PUSH, 32'h00000000, 5'd0, 1'b0));
        request_q.push_back(mk_req(KIND_PUSH, 32'hA5A5A5A5, 5'd0, 1'b0));
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd31, 1'b0));
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd1, 1'b1));
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd31, 1'b1));
        request_q.push_back(mk_req(KIND_PUSH, 32'h80000000, 5'd0, 1'b0));
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd1, 1'b0));
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd8, 1'b1));
        request_q.push_back(mk_req(KIND_PUSH, 32'hF8000003, 5'd0, 1'b0));
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd24, 1'b0));
        request_q.push_back(mk_req(KIND_VAR, 32'h0, 5'd0, 1'b1));
        request_q.push_back(mk_req(KIND_PUSH, 32'h7FFFFFFF, 5'd0, 1'b0));
        request_q.push_back(mk_req(KIND_VAR, 32'h0, 5'd0, 1'b1));
        request_q.push_back(mk_req(KIND_PUSH, 32'hFFFFFFFF, 5'd0, 1'b0));
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd31, 1'b1));
        request_q.push_back(mk_req(KIND_VAR, 32'h0, 5'd0, 1'b0));

        // random phases over several limits
        wait_idle();
        set_bit_limit(bits_taken + POS_BITS'($urandom_range(0, 300)));
        queue_random(100);

        // limit lowered below what was already taken: even zero-width reads fail
        wait_idle();
        if (bits_taken != 0) begin
            set_bit_limit(bits_taken - 16'd1);
            request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd0, 1'b0));
            request_q.push_back(mk_req(KIND_VAR, 32'h0, 5'd0, 1'b1));
            request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd5, 1'b1));
        end
        // limit equal to the position: done at once
        wait_idle();
        set_bit_limit(bits_taken);
        request_q.push_back(mk_req(KIND_PUSH, 32'h12345678, 5'd0, 1'b0));
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd0, 1'b1));
        request_q.push_back(mk_req(KIND_FIXED, 32'h0, 5'd2, 1'b0));

        set_bit_limit(16'hFFFF);
        queue_random(100);
        wait_idle();
        set_bit_limit(bits_taken + POS_BITS'($urandom_range(0, 60)));
        queue_random(100);
        set_bit_limit(POS_BITS'($urandom_range(0, 65535)));
        queue_random(100);
        wait_idle();
        set_bit_limit(bits_taken + POS_BITS'($urandom_range(100, 600)));
        queue_random(100);

        wait_idle();
        if (expected_fields.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_fields.size()));

        $display("covered %0d pushes, %0d fixed reads, %0d prefixed reads, %0d spare kinds",
                 n_push, n_fixed, n_var, n_spare);
        $display("checked %0d results (%0d refused, %0d finished) over %0d limits",
                 n_results, n_refused, n_finished, n_settings);
        if (n_errors == 0) begin
            $display("[msb_first_bit_field_reader_unit] OK");
        end else begin
            $display("[msb_first_bit_field_reader_unit] ERROR");
        end
        $finish;
    end

endmodule
